// ===== hdl/slr_pkg.sv =====
// Shared types and fixed widths for the stereo linear resampler.
// No dependencies; every other file of the block imports this package.
package slr_pkg;

    localparam int SMP_W  = 16;  // sample width
    localparam int PH_W   = 10;  // stored phase width
    localparam int MAG_W  = 25;  // magnitude of the weighted sum
    localparam int PROD_W = 27;  // sample times weight, signed
    localparam int RCP_SH = 25;  // reciprocal scale shift
    localparam int RCP_W  = 26;  // reciprocal width
    localparam int QDEPTH = 4;   // front-to-back queue depth
    localparam int QPTR_W = 2;

    // One input pair as classified by the front end
    typedef struct packed {
        logic             first;
        logic [SMP_W-1:0] right;
        logic [SMP_W-1:0] left;
    } q_entry_t;

    // One output request from the sequencer to the interpolator
    typedef struct packed {
        logic [SMP_W-1:0] prev_l;
        logic [SMP_W-1:0] prev_r;
        logic [SMP_W-1:0] cur_l;
        logic [SMP_W-1:0] cur_r;
        logic [PH_W-1:0]  ph;
        logic             last;
    } issue_t;

endpackage

// ===== hdl/slr_front.sv =====
// Input side of the resampler: stream handshake and first-pair marking.
// Depends on slr_pkg; feeds slr_queue.
module slr_front
    import slr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
    input  logic        q_full,
    output logic        push,
    output q_entry_t    push_entry
);

    logic have_prev_reg, have_prev_next;

    assign s_tready = ~q_full;
    assign push     = s_tvalid & ~q_full;

    always_comb
    begin
        push_entry.left  = s_tdata[SMP_W-1:0];
        push_entry.right = s_tdata[2*SMP_W-1:SMP_W];
        push_entry.first = ~have_prev_reg;
        have_prev_next   = have_prev_reg | push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_prev_reg <= 1'b0;
        else
            have_prev_reg <= have_prev_next;
    end

endmodule

// ===== hdl/slr_queue.sv =====
// Small register queue between the resampler front end and sequencer.
// Depends on slr_pkg.
module slr_queue
    import slr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    output logic     q_valid,
    output q_entry_t head,
    input  logic     pop
);

    q_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hdl/slr_back.sv =====
// Phase sequencer of the resampler: walks the phase for each queued pair,
// issues up to two interpolation requests, skips the rest. Depends on slr_pkg.
module slr_back
    import slr_pkg::*;
#(
    parameter int SRC_FRAME = 882,
    parameter int DST_FRAME = 960
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  q_entry_t head,
    output logic     pop,
    output logic     iss_valid,
    output issue_t   iss,
    input  logic     pipe_ready
);

    localparam logic [PH_W:0] SRC_C = (PH_W+1)'(SRC_FRAME);
    localparam logic [PH_W:0] DST_C = (PH_W+1)'(DST_FRAME);

    logic [SMP_W-1:0] prev_l_reg, prev_l_next;
    logic [SMP_W-1:0] prev_r_reg, prev_r_next;
    logic [PH_W:0]    phase_reg, phase_next;
    logic [1:0]       cnt_reg, cnt_next;   // outputs issued for the current pair

    logic [PH_W:0]    ph_add;
    logic [PH_W:0]    end_now;
    logic [PH_W:0]    end_add;
    logic             at_end;
    logic             add_end;
    logic             finish;

    always_comb
    begin
        ph_add  = phase_reg + SRC_C;
        at_end  = (phase_reg >= DST_C);
        add_end = (ph_add >= DST_C);
        end_now = {1'b0, PH_W'(phase_reg - DST_C)};
        end_add = {1'b0, PH_W'(ph_add - DST_C)};

        iss.prev_l = prev_l_reg;
        iss.prev_r = prev_r_reg;
        iss.cur_l  = head.left;
        iss.cur_r  = head.right;
        iss.ph     = phase_reg[PH_W-1:0];
        iss.last   = (cnt_reg == 2'd1) | add_end;

        iss_valid  = 1'b0;
        finish     = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;

        if (q_valid)
        begin
            if (head.first)
            begin
                // first pair: only seed prev and clear the phase
                finish     = 1'b1;
                phase_next = '0;
            end
            else if (at_end)
            begin
                finish     = 1'b1;
                phase_next = end_now;
            end
            else if (cnt_reg != 2'd2)
            begin
                iss_valid = 1'b1;
                if (pipe_ready)
                begin
                    if (add_end)
                    begin
                        finish     = 1'b1;
                        phase_next = end_add;
                    end
                    else
                    begin
                        phase_next = ph_add;
                        cnt_next   = cnt_reg + 2'd1;
                    end
                end
            end
            else
            begin
                // drop outputs beyond the second, keep advancing phase
                if (add_end)
                begin
                    finish     = 1'b1;
                    phase_next = end_add;
                end
                else
                    phase_next = ph_add;
            end
        end

        pop         = finish;
        prev_l_next = finish ? head.left  : prev_l_reg;
        prev_r_next = finish ? head.right : prev_r_reg;
        if (finish)
            cnt_next = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            phase_reg  <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            prev_l_reg <= prev_l_next;
            prev_r_reg <= prev_r_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hdl/slr_interp.sv =====
// Five-stage interpolation datapath of the resampler with output register.
// Division by the output frame uses a reciprocal and one correction step.
// Depends on slr_pkg.
module slr_interp
    import slr_pkg::*;
#(
    parameter int DST_FRAME = 960
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        iss_valid,
    input  issue_t      iss,
    output logic        pipe_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    localparam logic signed [PH_W:0]  DST_W = (PH_W+1)'(DST_FRAME);
    localparam logic [MAG_W-1:0]      DST_X = MAG_W'(DST_FRAME);
    localparam logic [PH_W-1:0]       DST_D = PH_W'(DST_FRAME);
    localparam logic [RCP_W-1:0]      RCP   = RCP_W'((64'd1 << RCP_SH) / DST_FRAME);
    localparam int                    QP_W  = SMP_W + PH_W;

    logic en;

    // stage valids and last flags
    logic [4:0] v_reg, v_next;
    logic [4:0] last_reg;

    logic signed [PROD_W-1:0] p0_reg [2];
    logic signed [PROD_W-1:0] p1_reg [2];
    logic [MAG_W-1:0]         x2_reg [2];
    logic [MAG_W-1:0]         x3_reg [2];
    logic [MAG_W-1:0]         x4_reg [2];
    logic [1:0]               s2_reg, s3_reg, s4_reg;
    logic [SMP_W-1:0]         q3_reg [2];
    logic [SMP_W-1:0]         q4_reg [2];
    logic [QP_W-1:0]          qd4_reg [2];
    logic [SMP_W-1:0]         o5_reg [2];

    logic signed [PH_W:0]        w0, w1;
    logic signed [SMP_W-1:0]     a_in [2];
    logic signed [SMP_W-1:0]     b_in [2];
    logic signed [PROD_W-1:0]    p0_c [2];
    logic signed [PROD_W-1:0]    p1_c [2];
    logic signed [PROD_W-1:0]    sum_c [2];
    logic [PROD_W-1:0]           mag_c [2];
    logic [MAG_W+RCP_W-1:0]      rp_c [2];
    logic [MAG_W-1:0]            r_c [2];
    logic [SMP_W-1:0]            q_c [2];
    logic [SMP_W-1:0]            o_c [2];

    // hold everything while the output register is full and not taken
    assign en         = ~v_reg[4] | m_tready;
    assign pipe_ready = en;
    assign m_tvalid   = v_reg[4];
    assign m_tlast    = last_reg[4];
    assign m_tdata    = {o5_reg[1], o5_reg[0]};

    always_comb
    begin
        w1      = $signed({1'b0, iss.ph});
        w0      = DST_W - w1;
        a_in[0] = $signed(iss.prev_l);
        a_in[1] = $signed(iss.prev_r);
        b_in[0] = $signed(iss.cur_l);
        b_in[1] = $signed(iss.cur_r);
        v_next  = {v_reg[3:0], iss_valid};
        for (int i = 0; i < 2; i++)
        begin
            p0_c[i]  = a_in[i] * w0;
            p1_c[i]  = b_in[i] * w1;
            sum_c[i] = p0_reg[i] + p1_reg[i];
            mag_c[i] = sum_c[i][PROD_W-1] ? PROD_W'(-sum_c[i]) : PROD_W'(sum_c[i]);
            rp_c[i]  = x2_reg[i] * RCP;
            // estimate is exact or one low; bump it once if the remainder allows
            r_c[i]   = x4_reg[i] - MAG_W'(qd4_reg[i]);
            q_c[i]   = q4_reg[i] + SMP_W'(r_c[i] >= DST_X);
            o_c[i]   = s4_reg[i] ? SMP_W'(-q_c[i]) : q_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[3:0], iss.last};
            for (int i = 0; i < 2; i++)
            begin
                p0_reg[i]  <= p0_c[i];
                p1_reg[i]  <= p1_c[i];
                x2_reg[i]  <= mag_c[i][MAG_W-1:0];
                s2_reg[i]  <= sum_c[i][PROD_W-1];
                q3_reg[i]  <= rp_c[i][RCP_SH+SMP_W-1:RCP_SH];
                x3_reg[i]  <= x2_reg[i];
                s3_reg[i]  <= s2_reg[i];
                qd4_reg[i] <= q3_reg[i] * DST_D;
                q4_reg[i]  <= q3_reg[i];
                x4_reg[i]  <= x3_reg[i];
                s4_reg[i]  <= s3_reg[i];
                o5_reg[i]  <= o_c[i];
            end
        end
    end

endmodule

// ===== hdl/stereo_linear_resampler.sv =====
// Top level of the stereo linear-interpolation resampler.
// Depends on slr_pkg, slr_front, slr_queue, slr_back and slr_interp.
//
// Channel   Direction  Transfer
// s_*       in         one stereo pair: left_sample [15:0], right_sample [31:16]
// m_*       out        one result: left_out [15:0], right_out [31:16], tlast = last
//
// The front end marks the very first pair and pushes pairs into a four-entry
// queue. The sequencer advances the phase by SRC_FRAME per output and issues
// one output per cycle while the interpolator is ready; a pair issues one or
// two outputs with the default ratio, about 1.09 on average. Pairs that call
// for more than two outputs skip the rest while the phase keeps advancing.
// The first pair only seeds the previous sample and clears the phase.
// An issued output reaches m_tdata through the product, magnitude, estimate,
// correction and output registers. A stall on m_tready freezes the pipeline;
// the queue keeps taking pairs until it is full. Reset (rst_n low, asynchronous)
// clears the previous pair, the phase and the first-pair flag.
module stereo_linear_resampler
    import slr_pkg::*;
#(
    parameter int SRC_FRAME = 882,
    parameter int DST_FRAME = 960
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out [15:0], right_out [31:16]
    output logic        m_tlast
);

    logic     q_full;
    logic     push;
    q_entry_t push_entry;
    logic     q_valid;
    q_entry_t head;
    logic     pop;
    logic     iss_valid;
    issue_t   iss;
    logic     pipe_ready;

    // accept and classify input pairs
    slr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouple the input handshake from the sequencer
    slr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop)
    );

    // walk the phase and issue interpolation requests
    slr_back #(
        .SRC_FRAME (SRC_FRAME),
        .DST_FRAME (DST_FRAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .iss_valid  (iss_valid),
        .iss        (iss),
        .pipe_ready (pipe_ready)
    );

    // weight, sum and divide; hold the result for the output transfer
    slr_interp #(
        .DST_FRAME (DST_FRAME)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .iss_valid  (iss_valid),
        .iss        (iss),
        .pipe_ready (pipe_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
